FILE: hw/rtl/csk_pkg.sv
// Shared types and constants for the column strip keypoint finder.
// Depends on nothing; every other file refers to it by scoped names.
package csk_pkg;

    localparam int MAX_DIM_DEF = 2048;

    localparam int STEP_W  = 7;
    localparam int GAP_W   = 12;
    localparam int CFG_W   = 12;
    localparam int WHITE_W = 12;
    localparam int BLACK_W = 13;
    localparam int X_W     = 18;
    localparam int Y_W     = 18;
    localparam int HH_W    = 17;

    localparam int WHITE_SAT = 4095;
    localparam int BLACK_SAT = 8191;
    localparam int X_MAX     = 262143;
    localparam int HH_MAX    = 131071;

    localparam logic [STEP_W-1:0] STEP_RESET = 7'd2;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 12'd1;

    typedef enum logic [0:0] {
        CFG_SCALE_STEP = 1'b0,
        CFG_MIN_GAP    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [X_W-1:0]  point_x;
        logic [Y_W-1:0]  point_y;
        logic [HH_W-1:0] half_height;
    } t_point;

endpackage

FILE: hw/rtl/csk_strip_tracker.sv
// Run-length state per column and the strip check for each accepted word.
// Depends on csk_pkg.
module csk_strip_tracker #(
    parameter int MAX_DIM = csk_pkg::MAX_DIM_DEF,
    localparam int COL_W  = $clog2(MAX_DIM),
    localparam int ROW_W  = $clog2(2 * MAX_DIM),
    localparam int BASE_W = ((ROW_W > csk_pkg::BLACK_W) ? ROW_W : csk_pkg::BLACK_W) + 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_pixel_set,
    input  logic                            i_last_in_column,
    input  logic                            i_first_of_frame,
    input  logic [csk_pkg::GAP_W-1:0]       i_min_gap,
    output logic                            o_emit,
    output logic [COL_W-1:0]                o_col,
    output logic signed [BASE_W-1:0]        o_base,
    output logic [csk_pkg::WHITE_W-1:0]     o_white_len
);

    localparam logic [ROW_W-1:0] ROW_SAT = ROW_W'(2 * MAX_DIM - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_DIM - 1);

    logic [COL_W-1:0]               r_col, n_col;
    logic [ROW_W-1:0]               r_row, n_row;
    logic [csk_pkg::BLACK_W-1:0]    r_bp, n_bp, r_br, n_br;
    logic [csk_pkg::WHITE_W-1:0]    r_wp, n_wp, r_wr, n_wr;
    logic                           r_open, n_open;

    logic [COL_W-1:0]               e_col;
    logic [ROW_W-1:0]               e_row;
    logic [csk_pkg::BLACK_W-1:0]    e_bp, e_br, mg;
    logic [csk_pkg::WHITE_W-1:0]    e_wp, e_wr;
    logic [csk_pkg::BLACK_W:0]      end_sum;
    logic [csk_pkg::BLACK_W-1:0]    end_black;
    logic                           chk_a, chk_b;
    logic signed [BASE_W-1:0]       base_a, base_b;

    always_comb begin
        mg = csk_pkg::BLACK_W'(i_min_gap);
        e_col = i_first_of_frame ? '0 : r_col;
        if (r_open && !i_first_of_frame) begin
            e_row = r_row;
            e_bp  = r_bp;
            e_br  = r_br;
            e_wp  = r_wp;
            e_wr  = r_wr;
        end else begin
            e_row = '0;
            e_bp  = '0;
            e_br  = mg;
            e_wp  = '0;
            e_wr  = '0;
        end

        n_row = e_row;
        n_bp  = e_bp;
        n_br  = e_br;
        n_wp  = e_wp;
        n_wr  = e_wr;
        chk_a = 1'b0;
        base_a = $signed(BASE_W'(e_row)) - $signed(BASE_W'(e_br));

        if (i_pixel_set) begin
            if (e_wr == '0) begin
                chk_a = (e_bp >= mg) && (e_br >= mg) && (e_wp != '0);
                n_bp  = e_br;
                n_br  = '0;
            end
            if (e_wr < csk_pkg::WHITE_W'(csk_pkg::WHITE_SAT)) n_wr = e_wr + 1'b1;
        end else begin
            if (e_br == '0) begin
                n_wp = e_wr;
                n_wr = '0;
            end
            if (e_br < csk_pkg::BLACK_W'(csk_pkg::BLACK_SAT)) n_br = e_br + 1'b1;
        end
        if (e_row < ROW_SAT) n_row = e_row + 1'b1;

        // Bottom of column counts as a further black gap of min_gap rows.
        end_sum   = (csk_pkg::BLACK_W + 1)'(n_br) + (csk_pkg::BLACK_W + 1)'(mg);
        end_black = (end_sum > (csk_pkg::BLACK_W + 1)'(csk_pkg::BLACK_SAT))
                  ? csk_pkg::BLACK_W'(csk_pkg::BLACK_SAT)
                  : end_sum[csk_pkg::BLACK_W-1:0];
        chk_b  = (n_bp >= mg) && (end_black >= mg) && (n_wp != '0);
        base_b = $signed(BASE_W'(n_row)) - $signed(BASE_W'(n_br));

        n_col  = e_col;
        n_open = 1'b1;
        if (i_last_in_column) begin
            n_br   = end_black;
            n_col  = (e_col == COL_LAST) ? '0 : e_col + 1'b1;
            n_open = 1'b0;
        end

        // In-column check wins over the end-of-column check.
        o_emit      = chk_a || (i_last_in_column && chk_b);
        o_col       = e_col;
        o_base      = chk_a ? base_a : base_b;
        o_white_len = chk_a ? e_wp : n_wp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bp   <= '0;
            r_br   <= '0;
            r_wp   <= '0;
            r_wr   <= '0;
            r_open <= 1'b0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_bp   <= n_bp;
            r_br   <= n_br;
            r_wp   <= n_wp;
            r_wr   <= n_wr;
            r_open <= n_open;
        end
    end

endmodule

FILE: hw/rtl/csk_point_calc.sv
// Scales a passing strip to full-resolution coordinates with saturation.
// Depends on csk_pkg.
module csk_point_calc #(
    parameter int MAX_DIM = csk_pkg::MAX_DIM_DEF,
    localparam int COL_W  = $clog2(MAX_DIM),
    localparam int ROW_W  = $clog2(2 * MAX_DIM),
    localparam int BASE_W = ((ROW_W > csk_pkg::BLACK_W) ? ROW_W : csk_pkg::BLACK_W) + 1
) (
    input  logic [COL_W-1:0]                i_col,
    input  logic signed [BASE_W-1:0]        i_base,
    input  logic [csk_pkg::WHITE_W-1:0]     i_white_len,
    input  logic [csk_pkg::STEP_W-1:0]      i_scale_step,
    output csk_pkg::t_point                 o_point
);

    localparam int XP_W = COL_W + csk_pkg::STEP_W + 1;
    localparam int XE_W = (XP_W > csk_pkg::X_W) ? XP_W : csk_pkg::X_W;
    localparam int HP_W = csk_pkg::WHITE_W + csk_pkg::STEP_W - 1;
    localparam int YE_W = BASE_W + csk_pkg::STEP_W + 2;

    logic [csk_pkg::STEP_W-2:0] half;
    logic [XE_W-1:0]            v_x;
    logic [HP_W-1:0]            v_hh;
    logic signed [YE_W-1:0]     v_y;

    always_comb begin
        half = i_scale_step[csk_pkg::STEP_W-1:1];
        v_x  = XE_W'(i_col) * XE_W'(i_scale_step) + XE_W'(half);
        v_hh = HP_W'(i_white_len) * HP_W'(half);
        v_y  = YE_W'(i_base) * $signed(YE_W'(i_scale_step)) - $signed(YE_W'(v_hh));

        o_point.point_x = (v_x > XE_W'(csk_pkg::X_MAX))
                        ? csk_pkg::X_W'(csk_pkg::X_MAX) : v_x[csk_pkg::X_W-1:0];
        if (v_y < 0) begin
            o_point.point_y = '0;
        end else if (v_y > $signed(YE_W'(csk_pkg::X_MAX))) begin
            o_point.point_y = csk_pkg::Y_W'(csk_pkg::X_MAX);
        end else begin
            o_point.point_y = v_y[csk_pkg::Y_W-1:0];
        end
        o_point.half_height = (v_hh > HP_W'(csk_pkg::HH_MAX))
                            ? csk_pkg::HH_W'(csk_pkg::HH_MAX) : v_hh[csk_pkg::HH_W-1:0];
    end

endmodule

FILE: hw/rtl/csk_out_skid.sv
// Output register with one skid entry for keypoint words.
// Depends on csk_pkg.
module csk_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  csk_pkg::t_point     i_data,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output csk_pkg::t_point     o_data
);

    logic               r_out_valid, r_skid_valid;
    csk_pkg::t_point    r_out, r_skid;

    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

FILE: hw/rtl/column_strip_keypoint_finder.sv
// Top level of the column strip keypoint finder.
// Depends on csk_pkg, csk_strip_tracker, csk_point_calc and csk_out_skid.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one mask pixel per word,
//   column-major, top to bottom, with last_in_column on the bottom pixel and
//   first_of_frame on the first pixel of a frame.
//   Output channel (o_out_valid / i_out_ready) carries one keypoint word:
//   column centre, strip centre and half height in full-resolution pixels.
//   A pixel yields zero or one keypoint.
//   Output path: the keypoint of the pixel that closes its strip is registered
//   into the output register, or into the skid entry while the output stalls.
//   Throughput: one pixel per cycle while o_in_ready is high; the run counters
//   update once per pixel; the check and scaling are combinational, then registered.
//   Stall: an output register plus one skid entry hold results; while the
//   skid entry is full, o_in_ready drops until the receiver takes a word.
//   Reset (i_rst_n low, synchronous): drop pending keypoints, zero the column
//   counter, close the column, load scale_step 2 and min_gap 1.
//   Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is
//   high; index 0 scale_step (low 7 bits), index 1 min_gap. Write only idle.
module column_strip_keypoint_finder #(
    parameter int MAX_DIM = csk_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [csk_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_pixel_set,
    input  logic                        i_last_in_column,
    input  logic                        i_first_of_frame,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [csk_pkg::X_W-1:0]     o_point_x,
    output logic [csk_pkg::Y_W-1:0]     o_point_y,
    output logic [csk_pkg::HH_W-1:0]    o_half_height
);

    localparam int COL_W  = $clog2(MAX_DIM);
    localparam int ROW_W  = $clog2(2 * MAX_DIM);
    localparam int BASE_W = ((ROW_W > csk_pkg::BLACK_W) ? ROW_W : csk_pkg::BLACK_W) + 1;

    logic [csk_pkg::STEP_W-1:0]     r_scale_step;
    logic [csk_pkg::GAP_W-1:0]      r_min_gap;

    logic                           accept, emit, room;
    logic [COL_W-1:0]               chk_col;
    logic signed [BASE_W-1:0]       chk_base;
    logic [csk_pkg::WHITE_W-1:0]    chk_white;
    csk_pkg::t_point                point, out_point;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_step <= csk_pkg::STEP_RESET;
            r_min_gap    <= csk_pkg::GAP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == csk_pkg::CFG_SCALE_STEP) begin
                r_scale_step <= i_cfg_data[csk_pkg::STEP_W-1:0];
            end
            if (i_cfg_idx == csk_pkg::CFG_MIN_GAP) begin
                r_min_gap <= i_cfg_data[csk_pkg::GAP_W-1:0];
            end
        end
    end

    // Take a pixel whenever the skid entry is free.
    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    csk_strip_tracker #(.MAX_DIM(MAX_DIM)) u_tracker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_pixel_set      (i_pixel_set),
        .i_last_in_column (i_last_in_column),
        .i_first_of_frame (i_first_of_frame),
        .i_min_gap        (r_min_gap),
        .o_emit           (emit),
        .o_col            (chk_col),
        .o_base           (chk_base),
        .o_white_len      (chk_white)
    );

    csk_point_calc #(.MAX_DIM(MAX_DIM)) u_calc (
        .i_col        (chk_col),
        .i_base       (chk_base),
        .i_white_len  (chk_white),
        .i_scale_step (r_scale_step),
        .o_point      (point)
    );

    // Push only words that carry a keypoint.
    csk_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && emit),
        .i_data  (point),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_point)
    );

    assign o_point_x     = out_point.point_x;
    assign o_point_y     = out_point.point_y;
    assign o_half_height = out_point.half_height;

endmodule

FILE: hw/rtl/csk_checker.sv
// Port-level checks for the column strip keypoint finder, bound to the top.
// Depends on csk_pkg and column_strip_keypoint_finder.
module csk_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [csk_pkg::X_W-1:0]     o_point_x,
    input  logic [csk_pkg::Y_W-1:0]     o_point_y,
    input  logic [csk_pkg::HH_W-1:0]    o_half_height
);

    // Hold a stalled keypoint word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_point_x)
            && $stable(o_point_y) && $stable(o_half_height))
        else $error("stalled keypoint word changed");

    // Reset drops any pending keypoint.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("keypoint valid after reset");

    // Back-pressure only follows a stall with a word waiting.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && $past(o_out_valid && !i_out_ready))
        else $error("input ready low without a stalled output");

    // Ready returns once the receiver takes a word.
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && i_out_ready |=> o_in_ready)
        else $error("input ready stuck after output drain");

endmodule

bind column_strip_keypoint_finder csk_checker u_csk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_point_x     (o_point_x),
    .o_point_y     (o_point_y),
    .o_half_height (o_half_height)
);
